FILE: sv/lru_pr_pkg.sv
// shared types and constants for the lru page replacement unit
package lru_pr_pkg;

  localparam int DEF_MAX_FRAMES = 16;
  localparam int DEF_PAGE_BITS  = 16;

  localparam int TIME_W = 32;
  localparam int FAULT_W = 32;
  localparam int CFG_W = 5;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

  // word index taken from paddr[2]
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  // flags that walk down the cell chain with each search word
  typedef struct packed {
    logic valid;
    logic hit;
    logic free;
    logic min_set;
  } srch_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } ctrl_state_t;

endpackage

FILE: sv/lru_page_replacement_unit.sv
// top level: lru page replacement with a chain of frame cells and a small controller
//
//  channel | dir | handshake            | contents
//  in_     | in  | in_tvalid/in_tready  | tdata: page
//  out_    | out | out_tvalid/out_tready| tdata: frame_index, victim_page, fault_total;
//          |     |                      | tuser: hit, evicted
//  cfg_    | in  | apb psel/penable     | reg 0 at 0x0: frames_in_use
//
// an accepted word walks one cell per cycle through all MAX_FRAMES cells into the tail
// registers, then the finish state commits the chosen frame and loads the result.
// one word is in flight at a time.
// synchronous reset clears valid bits, last-use times, the request clock and fault count.
// a stalled result holds in the output register; the next word may already be accepted
// and waits in its final step until the result is taken.
module lru_page_replacement_unit #(
  parameter int MAX_FRAMES = lru_pr_pkg::DEF_MAX_FRAMES,
  parameter int PAGE_BITS  = lru_pr_pkg::DEF_PAGE_BITS,
  localparam int IN_W  = ((PAGE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((4 + PAGE_BITS + 32 + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_W-1:0]               in_tdata,     // page
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_W-1:0]              out_tdata,    // frame_index[3:0], victim_page, fault_total
  output logic [1:0]                    out_tuser,    // hit, evicted
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lru_pr_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [lru_pr_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [lru_pr_pkg::APB_DW-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import lru_pr_pkg::*;

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  // configuration
  logic [CFG_W-1:0] frames_cfg_r;
  logic             cfg_wr;
  logic [31:0]      cfg_wide;
  logic [CNT_W-1:0] n_active;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[2] == REG_FRAMES_IN_USE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_cfg_r <= FRAMES_RESET;
    end else if (cfg_wr) begin
      frames_cfg_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_FRAMES_IN_USE) ? APB_DW'(frames_cfg_r) : '0;

  // zero acts as one, above the frame count clamps to it
  assign cfg_wide = 32'(frames_cfg_r);
  always_comb begin
    priority if (cfg_wide == 32'd0) begin
      n_active = CNT_W'(1);
    end else if (cfg_wide > 32'(MAX_FRAMES)) begin
      n_active = CNT_W'(MAX_FRAMES);
    end else begin
      n_active = cfg_wide[CNT_W-1:0];
    end
  end

  // control
  ctrl_state_t state_r, state_nxt;
  logic [TIME_W-1:0]  req_clock_r;
  logic [FAULT_W-1:0] fault_r;
  logic [FAULT_W-1:0] fault_nxt;
  logic               in_acc;
  logic               commit;

  // cell chain wiring, stage 0 fed from the input port
  srch_flags_t          ch_flags    [MAX_FRAMES+1];
  logic [PAGE_BITS-1:0] ch_page     [MAX_FRAMES+1];
  logic [TIME_W-1:0]    ch_time     [MAX_FRAMES+1];
  logic [IDX_W-1:0]     ch_hit_idx  [MAX_FRAMES+1];
  logic [IDX_W-1:0]     ch_free_idx [MAX_FRAMES+1];
  logic [TIME_W-1:0]    ch_min_time [MAX_FRAMES+1];
  logic [IDX_W-1:0]     ch_min_idx  [MAX_FRAMES+1];
  logic [PAGE_BITS-1:0] ch_min_tag  [MAX_FRAMES+1];

  // captured tail word
  srch_flags_t          res_flags_r;
  logic [PAGE_BITS-1:0] res_page_r;
  logic [TIME_W-1:0]    res_time_r;
  logic [IDX_W-1:0]     res_hit_idx_r;
  logic [IDX_W-1:0]     res_free_idx_r;
  logic [IDX_W-1:0]     res_min_idx_r;
  logic [PAGE_BITS-1:0] res_min_tag_r;

  logic                 dec_evict;
  logic [IDX_W-1:0]     dec_slot;
  logic [PAGE_BITS-1:0] dec_old;
  logic [31:0]          slot_wide;

  // output register
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic                 out_evict_r;
  logic [3:0]           out_fidx_r;
  logic [PAGE_BITS-1:0] out_old_r;
  logic [FAULT_W-1:0]   out_fault_r;

  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_WALK;
      ST_WALK:   if (ch_flags[MAX_FRAMES].valid) state_nxt = ST_FINISH;
      ST_FINISH: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    commit    = (state_r == ST_FINISH) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      req_clock_r <= '0;
      fault_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        req_clock_r <= req_clock_r + 1'b1;
      end
      if (commit) begin
        fault_r <= fault_nxt;
      end
    end
  end

  assign ch_flags[0]    = '{valid: in_acc, hit: 1'b0, free: 1'b0, min_set: 1'b0};
  assign ch_page[0]     = in_tdata[PAGE_BITS-1:0];
  assign ch_time[0]     = req_clock_r + 1'b1;
  assign ch_hit_idx[0]  = '0;
  assign ch_free_idx[0] = '0;
  assign ch_min_time[0] = '0;
  assign ch_min_idx[0]  = '0;
  assign ch_min_tag[0]  = '0;

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    lru_pr_cell #(
      .CELL_ID    (g),
      .PAGE_BITS  (PAGE_BITS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .n_active     (n_active),
      .in_flags     (ch_flags[g]),
      .in_page      (ch_page[g]),
      .in_time      (ch_time[g]),
      .in_hit_idx   (ch_hit_idx[g]),
      .in_free_idx  (ch_free_idx[g]),
      .in_min_time  (ch_min_time[g]),
      .in_min_idx   (ch_min_idx[g]),
      .in_min_tag   (ch_min_tag[g]),
      .out_flags    (ch_flags[g+1]),
      .out_page     (ch_page[g+1]),
      .out_time     (ch_time[g+1]),
      .out_hit_idx  (ch_hit_idx[g+1]),
      .out_free_idx (ch_free_idx[g+1]),
      .out_min_time (ch_min_time[g+1]),
      .out_min_idx  (ch_min_idx[g+1]),
      .out_min_tag  (ch_min_tag[g+1]),
      .wr_en        (commit),
      .wr_idx       (dec_slot),
      .wr_page      (res_page_r),
      .wr_time      (res_time_r)
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_flags_r <= '0;
    end else if (ch_flags[MAX_FRAMES].valid) begin
      res_flags_r <= ch_flags[MAX_FRAMES];
    end
  end

  always_ff @(posedge clk) begin
    if (ch_flags[MAX_FRAMES].valid) begin
      res_page_r     <= ch_page[MAX_FRAMES];
      res_time_r     <= ch_time[MAX_FRAMES];
      res_hit_idx_r  <= ch_hit_idx[MAX_FRAMES];
      res_free_idx_r <= ch_free_idx[MAX_FRAMES];
      res_min_idx_r  <= ch_min_idx[MAX_FRAMES];
      res_min_tag_r  <= ch_min_tag[MAX_FRAMES];
    end
  end

  // hit beats free frame beats oldest frame
  always_comb begin
    dec_evict = !res_flags_r.hit && !res_flags_r.free;
    priority if (res_flags_r.hit) begin
      dec_slot = res_hit_idx_r;
    end else if (res_flags_r.free) begin
      dec_slot = res_free_idx_r;
    end else begin
      dec_slot = res_min_idx_r;
    end
    dec_old = dec_evict ? res_min_tag_r : '0;
    if (!res_flags_r.hit && (fault_r != '1)) begin
      fault_nxt = fault_r + 1'b1;
    end else begin
      fault_nxt = fault_r;
    end
  end

  assign slot_wide = 32'(dec_slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r   <= res_flags_r.hit;
      out_evict_r <= dec_evict;
      out_fidx_r  <= slot_wide[3:0];
      out_old_r   <= dec_old;
      out_fault_r <= fault_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_fault_r, out_old_r, out_fidx_r});
  assign out_tuser  = {out_evict_r, out_hit_r};

endmodule

FILE: sv/lru_pr_cell.sv
// one frame cell: holds tag, valid and last-use time, refines the passing search word
module lru_pr_cell #(
  parameter int CELL_ID    = 0,
  parameter int PAGE_BITS  = lru_pr_pkg::DEF_PAGE_BITS,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [CNT_W-1:0]              n_active,
  // search word from the left neighbor
  input  lru_pr_pkg::srch_flags_t       in_flags,
  input  logic [PAGE_BITS-1:0]          in_page,
  input  logic [lru_pr_pkg::TIME_W-1:0] in_time,
  input  logic [IDX_W-1:0]              in_hit_idx,
  input  logic [IDX_W-1:0]              in_free_idx,
  input  logic [lru_pr_pkg::TIME_W-1:0] in_min_time,
  input  logic [IDX_W-1:0]              in_min_idx,
  input  logic [PAGE_BITS-1:0]          in_min_tag,
  // search word to the right neighbor
  output lru_pr_pkg::srch_flags_t       out_flags,
  output logic [PAGE_BITS-1:0]          out_page,
  output logic [lru_pr_pkg::TIME_W-1:0] out_time,
  output logic [IDX_W-1:0]              out_hit_idx,
  output logic [IDX_W-1:0]              out_free_idx,
  output logic [lru_pr_pkg::TIME_W-1:0] out_min_time,
  output logic [IDX_W-1:0]              out_min_idx,
  output logic [PAGE_BITS-1:0]          out_min_tag,
  // frame update
  input  logic                          wr_en,
  input  logic [IDX_W-1:0]              wr_idx,
  input  logic [PAGE_BITS-1:0]          wr_page,
  input  logic [lru_pr_pkg::TIME_W-1:0] wr_time
);
  import lru_pr_pkg::*;

  localparam logic [IDX_W-1:0] ID_I = IDX_W'(CELL_ID);
  localparam logic [CNT_W-1:0] ID_C = CNT_W'(CELL_ID);

  logic [PAGE_BITS-1:0] tag_r;
  logic                 valid_r;
  logic [TIME_W-1:0]    last_use_r;

  srch_flags_t          flags_nxt;
  logic [IDX_W-1:0]     hit_idx_nxt;
  logic [IDX_W-1:0]     free_idx_nxt;
  logic [TIME_W-1:0]    min_time_nxt;
  logic [IDX_W-1:0]     min_idx_nxt;
  logic [PAGE_BITS-1:0] min_tag_nxt;

  srch_flags_t          flags_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [TIME_W-1:0]    time_r;
  logic [IDX_W-1:0]     hit_idx_r;
  logic [IDX_W-1:0]     free_idx_r;
  logic [TIME_W-1:0]    min_time_r;
  logic [IDX_W-1:0]     min_idx_r;
  logic [PAGE_BITS-1:0] min_tag_r;

  logic active;
  assign active = (ID_C < n_active);

  always_comb begin
    flags_nxt    = in_flags;
    hit_idx_nxt  = in_hit_idx;
    free_idx_nxt = in_free_idx;
    min_time_nxt = in_min_time;
    min_idx_nxt  = in_min_idx;
    min_tag_nxt  = in_min_tag;
    // first match wins, so later cells leave an earlier find alone
    if (active && valid_r && (tag_r == in_page) && !in_flags.hit) begin
      flags_nxt.hit = 1'b1;
      hit_idx_nxt   = ID_I;
    end
    if (active && !valid_r && !in_flags.free) begin
      flags_nxt.free = 1'b1;
      free_idx_nxt   = ID_I;
    end
    // strict less-than keeps the lowest index on ties
    if (active && (!in_flags.min_set || (last_use_r < in_min_time))) begin
      flags_nxt.min_set = 1'b1;
      min_time_nxt      = last_use_r;
      min_idx_nxt       = ID_I;
      min_tag_nxt       = tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r     <= in_page;
    time_r     <= in_time;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    min_time_r <= min_time_nxt;
    min_idx_r  <= min_idx_nxt;
    min_tag_r  <= min_tag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      last_use_r <= '0;
    end else if (wr_en && (wr_idx == ID_I)) begin
      valid_r    <= 1'b1;
      last_use_r <= wr_time;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == ID_I)) begin
      tag_r <= wr_page;
    end
  end

  assign out_flags    = flags_r;
  assign out_page     = page_r;
  assign out_time     = time_r;
  assign out_hit_idx  = hit_idx_r;
  assign out_free_idx = free_idx_r;
  assign out_min_time = min_time_r;
  assign out_min_idx  = min_idx_r;
  assign out_min_tag  = min_tag_r;

endmodule
